### sv/zqs_pkg.sv
// zqs_pkg: shared constants, types and helper functions of the zone quantum scheduler
// used by zqs_irq_map, zqs_zone_table, zone_quantum_scheduler_core and its checker
// no dependencies
package zqs_pkg;

	// sizes
	localparam int ZONE_COUNT = 8;
	localparam int IRQ_SLOTS  = 4096;
	localparam int MAP_AW     = $clog2(IRQ_SLOTS);
	localparam int TIME_W     = 48;
	localparam int QUANTUM_W  = 32;
	localparam int ZONE_W     = 3;
	localparam int CAUSE_W    = 12;
	localparam int OP_W       = 3;

	localparam logic [ZONE_W:0]      ZONE_COUNT_W  = ZONE_COUNT[ZONE_W:0];
	localparam logic [MAP_AW-1:0]    MAP_LAST      = MAP_AW'(IRQ_SLOTS - 1);
	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 32'd10000;
	localparam logic [CAUSE_W-1:0]   TIMER_BIT     = 12'h080;
	localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};

	// opcodes
	localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OP_W-1:0] OP_RETURN   = 3'd1;
	localparam logic [OP_W-1:0] OP_YIELD    = 3'd2;
	localparam logic [OP_W-1:0] OP_WAIT     = 3'd3;
	localparam logic [OP_W-1:0] OP_IRQ      = 3'd4;
	localparam logic [OP_W-1:0] OP_WR_ZONE  = 3'd5;
	localparam logic [OP_W-1:0] OP_WR_MAP   = 3'd6;

	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [ZONE_W-1:0]  zone_t;
	typedef logic [CAUSE_W-1:0] cause_t;

	// zone record write request
	typedef struct packed {
		logic   we;
		zone_t  idx;
		logic   ie;
		cause_t bits;
		time_t  deadline;
	} zone_wr_t;

	// zone record read response
	typedef struct packed {
		logic   ie;
		time_t  deadline;
		cause_t or_mask;
	} zone_rd_t;

	// zone number modulo zone count
	function automatic zone_t zone_wrap(zone_t v);
		logic [ZONE_W:0] w;
		w = {1'b0, v};
		for (int k = 0; k < 8; k++) begin
			if (w >= ZONE_COUNT_W)
				w = w - ZONE_COUNT_W;
		end
		return w[ZONE_W-1:0];
	endfunction

	// round-robin successor of a zone below the zone count
	function automatic zone_t next_zone(zone_t c);
		logic [ZONE_W:0] n;
		n = {1'b0, c} + {{ZONE_W{1'b0}}, 1'b1};
		return (n >= ZONE_COUNT_W) ? '0 : n[ZONE_W-1:0];
	endfunction

	// saturating time sum
	function automatic time_t sat_add(time_t a, time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

### sv/zqs_irq_map.sv
// zqs_irq_map: interrupt-cause to zone map, one synchronous memory with registered read
// clears itself after reset by a sweep over all entries
// depends on zqs_pkg
module zqs_irq_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [zqs_pkg::MAP_AW-1:0] rd_addr,
	output zqs_pkg::zone_t            rd_data,
	input  logic                      wr_en,
	input  logic [zqs_pkg::MAP_AW-1:0] wr_addr,
	input  zqs_pkg::zone_t            wr_data,
	output logic                      clearing
);

	zqs_pkg::zone_t             mem [zqs_pkg::IRQ_SLOTS];
	logic                       clr_act_q;
	logic [zqs_pkg::MAP_AW-1:0] clr_addr_q;
	logic                       we;
	logic [zqs_pkg::MAP_AW-1:0] wa;
	zqs_pkg::zone_t             wd;

	// clear sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q  <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_act_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == zqs_pkg::MAP_LAST)
				clr_act_q <= 1'b0;
		end
	end

	// write port shared by sweep and updates
	always_comb begin
		we = clr_act_q | wr_en;
		wa = clr_act_q ? clr_addr_q : wr_addr;
		wd = clr_act_q ? '0 : wr_data;
	end

	// memory array
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data <= mem[rd_addr];
	end

	assign clearing = clr_act_q;

endmodule

### sv/zqs_zone_table.sv
// zqs_zone_table: per-zone records, deadline memory plus enable flags and masks
// gives the current zone's record and the OR of all enabled zone masks
// depends on zqs_pkg
module zqs_zone_table (
	input  logic               clk,
	input  logic               arst_n,
	input  zqs_pkg::zone_wr_t  wr,
	input  zqs_pkg::zone_t     rd_addr,
	output zqs_pkg::zone_rd_t  rd
);

	zqs_pkg::time_t  dl_mem [zqs_pkg::ZONE_COUNT];
	logic            ie_q   [zqs_pkg::ZONE_COUNT];
	zqs_pkg::cause_t mask_q [zqs_pkg::ZONE_COUNT];
	zqs_pkg::time_t  rd_dl_s1;
	logic            rd_ie_s1;
	zqs_pkg::cause_t or_mask;

	// enable flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < zqs_pkg::ZONE_COUNT; i++)
				ie_q[i] <= 1'b0;
			rd_ie_s1 <= 1'b0;
		end else begin
			if (wr.we)
				ie_q[wr.idx] <= wr.ie;
			rd_ie_s1 <= ie_q[rd_addr];
		end
	end

	// deadline memory and masks, meaningful only behind a set flag
	always_ff @(posedge clk) begin
		if (wr.we) begin
			dl_mem[wr.idx] <= wr.deadline;
			mask_q[wr.idx] <= wr.bits;
		end
		rd_dl_s1 <= dl_mem[rd_addr];
	end

	// or of enabled zone masks
	always_comb begin
		or_mask = '0;
		for (int i = 0; i < zqs_pkg::ZONE_COUNT; i++) begin
			if (ie_q[i])
				or_mask = or_mask | mask_q[i];
		end
	end

	assign rd.ie       = rd_ie_s1;
	assign rd.deadline = rd_dl_s1;
	assign rd.or_mask  = or_mask;

endmodule

### sv/zone_quantum_scheduler_core.sv
// zone_quantum_scheduler_core: round-robin time-slice scheduler, top level
// sequencer and scheduling state; uses zqs_irq_map, zqs_zone_table and zqs_pkg
//
// channel   | handshake          | fields
// ----------+--------------------+-------------------------------------------------------
// command   | start, busy        | opcode, now_time, irq_cause, zone_index,
//           |                    | zone_irq_enable, zone_enable_bits, zone_deadline_in
// result    | done (1-cycle)     | running_zone, timer_compare, irq_enable_mask, in_irq_mode
// config    | cfg_we             | cfg_wdata (time quantum)
//
// an item passes through the accept cycle, the opcode state ST_OP, the expiry catch-up
// states ST_CU1 and ST_CU2 and the state ST_FIN for the zone record read; done is set
// in ST_FIN and shows in the next cycle, where the following item can already be taken
// after reset the interrupt map is swept clear, one entry a cycle: busy stays high
// until all 4096 entries are cleared; configuration writes are taken at any time
// results are shown for one cycle only; the receiver cannot stall them
module zone_quantum_scheduler_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [zqs_pkg::OP_W-1:0]               opcode,
	input  logic [zqs_pkg::TIME_W-1:0]             now_time,
	input  logic [zqs_pkg::CAUSE_W-1:0]            irq_cause,
	input  logic [zqs_pkg::ZONE_W-1:0]             zone_index,
	input  logic                                   zone_irq_enable,
	input  logic [zqs_pkg::CAUSE_W-1:0]            zone_enable_bits,
	input  logic [zqs_pkg::TIME_W-1:0]             zone_deadline_in,
	input  logic                                   cfg_we,
	input  logic [zqs_pkg::QUANTUM_W-1:0]          cfg_wdata,
	output logic                                   done,
	output logic [zqs_pkg::ZONE_W-1:0]             running_zone,
	output logic [zqs_pkg::TIME_W-1:0]             timer_compare,
	output logic [zqs_pkg::CAUSE_W-1:0]            irq_enable_mask,
	output logic                                   in_irq_mode
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OP   = 3'd1;
	localparam logic [2:0] ST_CU1  = 3'd2;
	localparam logic [2:0] ST_CU2  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                    state_q;
	logic [zqs_pkg::QUANTUM_W-1:0] quantum_q;

	// scheduling state
	zqs_pkg::zone_t cur_q;
	zqs_pkg::zone_t fol_q;
	zqs_pkg::time_t sdl_q;
	zqs_pkg::time_t fsl_q;
	logic           irqm_q;

	// latched item
	logic [zqs_pkg::OP_W-1:0] op_q;
	zqs_pkg::time_t           now_q;
	zqs_pkg::cause_t          cause_q;
	zqs_pkg::zone_t           zi_q;
	logic                     zie_q;
	zqs_pkg::cause_t          zbits_q;
	zqs_pkg::time_t           zdl_q;

	// result registers
	logic            done_q;
	zqs_pkg::zone_t  res_zone_q;
	zqs_pkg::time_t  res_cmp_q;
	zqs_pkg::cause_t res_mask_q;
	logic            res_irqm_q;

	logic              accept;
	logic              map_clearing;
	zqs_pkg::zone_t    map_rd;
	logic              map_we;
	zqs_pkg::zone_wr_t zwr;
	zqs_pkg::zone_rd_t zrd;
	zqs_pkg::zone_t    zrd_addr;

	// advance and interrupt candidates
	zqs_pkg::time_t quantum_ext;
	zqs_pkg::time_t adv_sdl;
	zqs_pkg::zone_t adv_fol;
	logic           expired;
	logic           do_adv_op;
	zqs_pkg::time_t irq_fsl;
	zqs_pkg::time_t cmp_val;
	zqs_pkg::cause_t mask_val;

	assign accept = start & ~busy;
	assign busy   = (state_q != ST_IDLE) | map_clearing;

	// interrupt map, read at the accept edge, written in the opcode cycle
	assign map_we = (state_q == ST_OP) && (op_q == zqs_pkg::OP_WR_MAP);

	zqs_irq_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (irq_cause[zqs_pkg::MAP_AW-1:0]),
		.rd_data  (map_rd),
		.wr_en    (map_we),
		.wr_addr  (cause_q[zqs_pkg::MAP_AW-1:0]),
		.wr_data  (zqs_pkg::zone_wrap(zi_q)),
		.clearing (map_clearing)
	);

	// zone record write request
	always_comb begin
		zwr.we       = (state_q == ST_OP) && (op_q == zqs_pkg::OP_WR_ZONE);
		zwr.idx      = zqs_pkg::zone_wrap(zi_q);
		zwr.ie       = zie_q;
		zwr.bits     = zbits_q;
		zwr.deadline = zdl_q;
	end

	zqs_zone_table u_zones (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (zwr),
		.rd_addr (zrd_addr),
		.rd      (zrd)
	);

	// next-state candidates
	always_comb begin
		quantum_ext = {{(zqs_pkg::TIME_W - zqs_pkg::QUANTUM_W){1'b0}}, quantum_q};
		adv_sdl     = zqs_pkg::sat_add(now_q, fsl_q);
		adv_fol     = zqs_pkg::next_zone(fol_q);
		expired     = (now_q >= sdl_q);
		irq_fsl     = (sdl_q > now_q) ? (sdl_q - now_q) : '0;
		do_adv_op   = (op_q == zqs_pkg::OP_YIELD) || (op_q == zqs_pkg::OP_WAIT) ||
		              ((op_q == zqs_pkg::OP_RETURN) && !irqm_q);
		// zone after the second catch-up step
		zrd_addr    = expired ? fol_q : cur_q;
	end

	// compare value and interrupt enable mask
	always_comb begin
		cmp_val = sdl_q;
		if (zrd.ie && (zrd.deadline != '0) && (zrd.deadline < sdl_q))
			cmp_val = zrd.deadline;
		mask_val = irqm_q ? zqs_pkg::TIMER_BIT : (zqs_pkg::TIMER_BIT | zrd.or_mask);
	end

	// time quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quantum_q <= zqs_pkg::QUANTUM_RESET;
		else if (cfg_we)
			quantum_q <= cfg_wdata;
	end

	// sequencer and scheduling state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			fol_q   <= zqs_pkg::next_zone('0);
			sdl_q   <= {{(zqs_pkg::TIME_W - zqs_pkg::QUANTUM_W){1'b0}}, zqs_pkg::QUANTUM_RESET};
			fsl_q   <= {{(zqs_pkg::TIME_W - zqs_pkg::QUANTUM_W){1'b0}}, zqs_pkg::QUANTUM_RESET};
			irqm_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_OP;
				end
				ST_OP: begin
					if (do_adv_op) begin
						cur_q  <= fol_q;
						sdl_q  <= adv_sdl;
						fol_q  <= adv_fol;
						fsl_q  <= quantum_ext;
						irqm_q <= 1'b0;
					end else if (op_q == zqs_pkg::OP_IRQ) begin
						fol_q  <= cur_q;
						fsl_q  <= irq_fsl;
						cur_q  <= zqs_pkg::zone_wrap(map_rd);
						sdl_q  <= zqs_pkg::sat_add(now_q, quantum_ext);
						irqm_q <= 1'b1;
					end
					state_q <= ST_CU1;
				end
				ST_CU1, ST_CU2: begin
					if (expired) begin
						cur_q  <= fol_q;
						sdl_q  <= adv_sdl;
						fol_q  <= adv_fol;
						fsl_q  <= quantum_ext;
						irqm_q <= 1'b0;
					end
					state_q <= (state_q == ST_CU1) ? ST_CU2 : ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			now_q   <= now_time;
			cause_q <= irq_cause;
			zi_q    <= zone_index;
			zie_q   <= zone_irq_enable;
			zbits_q <= zone_enable_bits;
			zdl_q   <= zone_deadline_in;
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			res_zone_q <= cur_q;
			res_cmp_q  <= cmp_val;
			res_mask_q <= mask_val;
			res_irqm_q <= irqm_q;
		end
	end

	assign done            = done_q;
	assign running_zone    = res_zone_q;
	assign timer_compare   = res_cmp_q;
	assign irq_enable_mask = res_mask_q;
	assign in_irq_mode     = res_irqm_q;

endmodule

### sv/zqs_checker.sv
// zqs_checker: port-level assertions for zone_quantum_scheduler_core
// bound to the top level below; depends on zqs_pkg
module zqs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [zqs_pkg::CAUSE_W-1:0]       irq_enable_mask,
	input logic                              in_irq_mode
);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result appears only once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result shown while busy or without prior work");

	// one result per item, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// timer interrupt always enabled
	a_timer_bit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> irq_enable_mask[7])
		else $error("timer enable bit missing");

	// in interrupt mode only the timer is enabled
	a_irq_mask: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_irq_mode |-> irq_enable_mask == zqs_pkg::TIMER_BIT)
		else $error("zone masks enabled during interrupt service");

endmodule

bind zone_quantum_scheduler_core zqs_checker u_zqs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.irq_enable_mask (irq_enable_mask),
	.in_irq_mode     (in_irq_mode)
);

### tb/zone_quantum_scheduler_core_tb.sv
// zone_quantum_scheduler_core_tb: self-checking testbench for the zone quantum scheduler
// runs directed and random command items against a behavioral scheduling predictor
// depends on zqs_pkg and zone_quantum_scheduler_core
`timescale 1ns / 1ps

module zone_quantum_scheduler_core_tb;
	import zqs_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES = 6;

	// one command item and one scheduling result
	typedef struct {
		logic [OP_W-1:0] op;
		time_t           now;
		cause_t          cause;
		zone_t           zidx;
		logic            zie;
		cause_t          zbits;
		time_t           zdl;
	} sched_cmd_t;

	typedef struct {
		zone_t  zone;
		time_t  compare;
		cause_t mask;
		logic   irqm;
	} sched_result_t;

	// dut ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [OP_W-1:0]      opcode = '0;
	time_t                now_time = '0;
	cause_t               irq_cause = '0;
	zone_t                zone_index = '0;
	logic                 zone_irq_enable = 1'b0;
	cause_t               zone_enable_bits = '0;
	time_t                zone_deadline_in = '0;
	logic                 cfg_we = 1'b0;
	logic [QUANTUM_W-1:0] cfg_wdata = '0;
	logic                 done;
	zone_t                running_zone;
	time_t                timer_compare;
	cause_t               irq_enable_mask;
	logic                 in_irq_mode;

	// predicted scheduler state
	logic [QUANTUM_W-1:0] quantum_reg;
	zone_t                run_zone;
	zone_t                next_run_zone;
	time_t                slice_end;
	time_t                next_slice_len;
	logic                 irq_active;
	logic                 zone_ie [ZONE_COUNT];
	cause_t               zone_bits [ZONE_COUNT];
	time_t                zone_dl [ZONE_COUNT];
	zone_t                cause_map [IRQ_SLOTS];

	sched_result_t expected_sched_q [$];
	time_t         timer_now = '0;
	int            err_count = 0;
	int            items_sent = 0;
	int            results_checked = 0;
	int            irq_items = 0;
	int            quantum_writes = 0;
	int            cycle_count = 0;

	zone_quantum_scheduler_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.now_time        (now_time),
		.irq_cause       (irq_cause),
		.zone_index      (zone_index),
		.zone_irq_enable (zone_irq_enable),
		.zone_enable_bits(zone_enable_bits),
		.zone_deadline_in(zone_deadline_in),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.running_zone    (running_zone),
		.timer_compare   (timer_compare),
		.irq_enable_mask (irq_enable_mask),
		.in_irq_mode     (in_irq_mode)
	);

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// saturating time sum
	function automatic time_t time_add_sat(time_t a, time_t b);
		return (b > TIME_MAX - a) ? TIME_MAX : time_t'(a + b);
	endfunction

	function automatic void reset_predictor();
		quantum_reg = QUANTUM_RESET;
		run_zone = '0;
		next_run_zone = zone_t'(1 % ZONE_COUNT);
		slice_end = time_t'(QUANTUM_RESET);
		next_slice_len = time_t'(QUANTUM_RESET);
		irq_active = 1'b0;
		for (int k = 0; k < ZONE_COUNT; k++) begin
			zone_ie[k] = 1'b0;
			zone_bits[k] = '0;
			zone_dl[k] = '0;
		end
		for (int k = 0; k < IRQ_SLOTS; k++)
			cause_map[k] = '0;
	endfunction

	// round-robin switch with the pending slice of the following zone
	function automatic void rotate_zone(time_t now);
		run_zone = zone_t'(int'(next_run_zone) % ZONE_COUNT);
		slice_end = time_add_sat(now, next_slice_len);
		next_run_zone = zone_t'((int'(run_zone) + 1) % ZONE_COUNT);
		next_slice_len = time_t'(quantum_reg);
		irq_active = 1'b0;
	endfunction

	// save the rest of the slice and jump to the mapped handler zone
	function automatic void enter_irq(time_t now, cause_t cause);
		next_run_zone = run_zone;
		next_slice_len = (slice_end > now) ? time_t'(slice_end - now) : '0;
		run_zone = zone_t'(int'(cause_map[int'(cause) % IRQ_SLOTS]) % ZONE_COUNT);
		slice_end = time_add_sat(now, time_t'(quantum_reg));
		irq_active = 1'b1;
	endfunction

	// apply one accepted item and queue the expected scheduling result
	function automatic void schedule_step(sched_cmd_t c);
		sched_result_t r;
		zone_t zi;
		zi = zone_t'(int'(c.zidx) % ZONE_COUNT);
		case (c.op)
			OP_RETURN: begin
				if (!irq_active)
					rotate_zone(c.now);
			end
			OP_YIELD, OP_WAIT: begin
				rotate_zone(c.now);
			end
			OP_IRQ: begin
				enter_irq(c.now, c.cause);
			end
			OP_WR_ZONE: begin
				zone_ie[zi] = c.zie;
				zone_bits[zi] = c.zbits;
				zone_dl[zi] = c.zdl;
			end
			OP_WR_MAP: begin
				cause_map[int'(c.cause) % IRQ_SLOTS] = zi;
			end
			default: begin
			end
		endcase
		// bounded expiry catch-up
		for (int n = 0; n < 2 && c.now >= slice_end; n++)
			rotate_zone(c.now);
		r.zone = run_zone;
		r.compare = slice_end;
		if (zone_ie[run_zone] && zone_dl[run_zone] != '0 && zone_dl[run_zone] < slice_end)
			r.compare = zone_dl[run_zone];
		r.mask = TIMER_BIT;
		if (!irq_active) begin
			for (int k = 0; k < ZONE_COUNT; k++)
				if (zone_ie[k])
					r.mask = r.mask | zone_bits[k];
		end
		r.irqm = irq_active;
		expected_sched_q.push_back(r);
	endfunction

	// compare each result against the oldest prediction
	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_sched_q.size() == 0) begin
				$error("unexpected result: zone %0d compare %h", running_zone, timer_compare);
				err_count++;
			end else begin
				want = expected_sched_q.pop_front();
				results_checked++;
				if (running_zone !== want.zone) begin
					$error("running_zone: expected %0d, got %0d", want.zone, running_zone);
					err_count++;
				end
				if (timer_compare !== want.compare) begin
					$error("timer_compare: expected %h, got %h", want.compare, timer_compare);
					err_count++;
				end
				if (irq_enable_mask !== want.mask) begin
					$error("irq_enable_mask: expected %h, got %h", want.mask, irq_enable_mask);
					err_count++;
				end
				if (in_irq_mode !== want.irqm) begin
					$error("in_irq_mode: expected %b, got %b", want.irqm, in_irq_mode);
					err_count++;
				end
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 6);
		return $urandom_range(10, 60);
	endfunction

	// send one item: optional idle gap, then hold start until accepted
	task automatic send_item(input sched_cmd_t c, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= c.op;
		now_time <= c.now;
		irq_cause <= c.cause;
		zone_index <= c.zidx;
		zone_irq_enable <= c.zie;
		zone_enable_bits <= c.zbits;
		zone_deadline_in <= c.zdl;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		schedule_step(c);
		items_sent++;
		if (c.op == OP_IRQ)
			irq_items++;
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input time_t now, input cause_t cause,
			input zone_t zidx, input logic zie, input cause_t zbits, input time_t zdl);
		sched_cmd_t c;
		c.op = op;
		c.now = now;
		c.cause = cause;
		c.zidx = zidx;
		c.zie = zie;
		c.zbits = zbits;
		c.zdl = zdl;
		send_item(c, pick_gap());
	endtask

	// let every result drain before touching the quantum
	task automatic quiesce();
		start <= 1'b0;
		while (expected_sched_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
		cfg_wdata <= q;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum_reg = q;
		quantum_writes++;
	endtask

	// timer value for the next item: mostly creeping forward, sometimes jumping
	function automatic time_t pick_now();
		int unsigned r;
		logic [31:0] span;
		r = $urandom_range(0, 99);
		span = (quantum_reg == 0) ? 32'd16 : quantum_reg;
		if (r < 55)
			timer_now = time_add_sat(timer_now, time_t'($urandom_range(0, 200)));
		else if (r < 80)
			timer_now = time_add_sat(timer_now, time_t'($urandom_range(0, span)));
		else if (r < 90)
			timer_now = time_add_sat(timer_now, time_t'($urandom()));
		else if (r < 95)
			timer_now = time_t'({$urandom(), $urandom()});
		else if (r < 97)
			timer_now = TIME_MAX - time_t'($urandom_range(0, 1000));
		else
			timer_now = time_t'($urandom_range(0, 1000000));
		return timer_now;
	endfunction

	// causes are mostly drawn from small pools at both ends of the map so that mapped entries get hit
	function automatic cause_t pick_cause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return cause_t'($urandom_range(0, 15));
		else if (r < 60)
			return cause_t'(4080 + $urandom_range(0, 15));
		return cause_t'($urandom_range(0, 4095));
	endfunction

	function automatic sched_cmd_t make_random_cmd();
		sched_cmd_t c;
		int unsigned r;
		c.op = OP_TICK;
		c.now = pick_now();
		c.cause = cause_t'($urandom());
		c.zidx = zone_t'($urandom());
		c.zie = 1'($urandom());
		c.zbits = cause_t'($urandom());
		c.zdl = time_t'({$urandom(), $urandom()});
		// noise: any opcode, any time
		if ($urandom_range(0, 9) == 0) begin
			c.op = OP_W'($urandom_range(0, 7));
			c.now = time_t'({$urandom(), $urandom()});
			return c;
		end
		r = $urandom_range(0, 99);
		if (r < 20)
			c.op = OP_TICK;
		else if (r < 35)
			c.op = OP_RETURN;
		else if (r < 50)
			c.op = OP_YIELD;
		else if (r < 60)
			c.op = OP_WAIT;
		else if (r < 75)
			c.op = OP_IRQ;
		else if (r < 90)
			c.op = OP_WR_ZONE;
		else
			c.op = OP_WR_MAP;
		if (c.op == OP_IRQ || c.op == OP_WR_MAP)
			c.cause = pick_cause();
		if (c.op == OP_WR_ZONE) begin
			c.zie = ($urandom_range(0, 9) < 7);
			r = $urandom_range(0, 3);
			if (r == 0)
				c.zdl = '0;
			else if (r != 3)
				c.zdl = time_add_sat(c.now, time_t'($urandom_range(0, 20000)));
		end
		return c;
	endfunction

	// every opcode, field extremes, saturation, catch-up and the map wrap
	task automatic test_directed_ops();
		send_op(OP_TICK, '0, '0, '0, 1'b0, '0, '0);
		send_op(OP_WR_ZONE, 48'd10, '0, 3'd0, 1'b1, 12'hFFF, 48'd5000);
		send_op(OP_WR_ZONE, 48'd20, '0, 3'd7, 1'b1, 12'h001, TIME_MAX);
		send_op(OP_WR_MAP, 48'd30, 12'hFFF, 3'd7, 1'b0, '0, '0);
		send_op(OP_WR_MAP, 48'd40, 12'h000, 3'd3, 1'b0, '0, '0);
		send_op(OP_YIELD, 48'd100, '0, '0, 1'b0, '0, '0);
		send_op(OP_WAIT, 48'd200, '0, '0, 1'b0, '0, '0);
		send_op(OP_IRQ, 48'd300, 12'hFFF, '0, 1'b0, '0, '0);
		// return is dropped while the handler runs
		send_op(OP_RETURN, 48'd400, '0, '0, 1'b0, '0, '0);
		send_op(OP_SPARE, 48'd500, '0, '0, 1'b0, '0, '0);
		// long jump: slice expired, catch-up switches back to the interrupted zone
		send_op(OP_TICK, 48'd1000000, '0, '0, 1'b0, '0, '0);
		send_op(OP_IRQ, TIME_MAX - 48'd5, 12'h000, '0, 1'b0, '0, '0);
		send_op(OP_TICK, TIME_MAX, '0, '0, 1'b0, '0, '0);
		send_op(OP_RETURN, '0, '0, '0, 1'b0, '0, '0);
		send_op(OP_WR_ZONE, 48'd5, '0, 3'd3, 1'b0, 12'hAAA, 48'd1);
		send_op(OP_WR_ZONE, 48'd6, '0, 3'd5, 1'b1, 12'h555, '0);
	endtask

	// zero, one and full-scale slice lengths
	task automatic test_quantum_extremes();
		quiesce();
		set_quantum('0);
		send_op(OP_TICK, 48'd50, '0, '0, 1'b0, '0, '0);
		send_op(OP_YIELD, 48'd60, '0, '0, 1'b0, '0, '0);
		send_op(OP_IRQ, 48'd70, 12'h001, '0, 1'b0, '0, '0);
		quiesce();
		set_quantum(32'd1);
		send_op(OP_YIELD, 48'd80, '0, '0, 1'b0, '0, '0);
		quiesce();
		set_quantum(32'hFFFF_FFFF);
		send_op(OP_YIELD, TIME_MAX - 48'd10, '0, '0, 1'b0, '0, '0);
		send_op(OP_IRQ, 48'd1000, 12'hFFF, '0, 1'b0, '0, '0);
	endtask

	// random traffic over several quantum settings, with bursts of back-to-back items
	task automatic test_random_traffic();
		logic [QUANTUM_W-1:0] quanta [PHASES];
		bit burst;
		sched_cmd_t c;
		quanta[0] = $urandom_range(1, 50);
		quanta[1] = QUANTUM_RESET;
		quanta[2] = 32'd1;
		quanta[3] = 32'hFFFF_FFFF;
		quanta[4] = $urandom_range(100, 100000);
		quanta[5] = $urandom();
		burst = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			set_quantum(quanta[p]);
			timer_now = time_t'($urandom_range(0, 100000));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 40 == 0)
					burst = ($urandom_range(0, 9) < 3);
				c = make_random_cmd();
				send_item(c, burst ? 0 : pick_gap());
			end
		end
	endtask

	initial begin
		reset_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_quantum_extremes();
		test_random_traffic();
		quiesce();
		$display("covered %0d items (%0d interrupts) over %0d quantum settings",
			items_sent, irq_items, quantum_writes);
		$display("%0d results checked, %0d mismatches", results_checked, err_count);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### zone_quantum_scheduler_core.f
sv/zqs_pkg.sv
sv/zqs_irq_map.sv
sv/zqs_zone_table.sv
sv/zone_quantum_scheduler_core.sv
sv/zqs_checker.sv
tb/zone_quantum_scheduler_core_tb.sv
